// ===== hdl/kdsc_pkg.sv =====
// ----------------------------------------------------------------------------
// kdsc_pkg
// Shared types and constants for the four-key debounce and speed control.
// ----------------------------------------------------------------------------
package kdsc_pkg;

	localparam int unsigned NUM_KEYS  = 4;
	localparam int unsigned KEY_W     = 3;
	localparam int unsigned CNT_W     = 8;
	localparam int unsigned PERIOD_W  = 10;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DW    = 10;

	localparam logic [CNT_W-1:0]    PRESS_TICKS_RST   = 8'd8;
	localparam logic [CNT_W-1:0]    RELEASE_TICKS_RST = 8'd200;
	localparam logic [CNT_W-1:0]    PERIOD_STEP_RST   = 8'd10;
	localparam logic [PERIOD_W-1:0] PERIOD_MIN_RST    = 10'd10;
	localparam logic [PERIOD_W-1:0] PERIOD_MAX_RST    = 10'd400;
	localparam logic [PERIOD_W-1:0] PERIOD_START_RST  = 10'd100;

	localparam logic [KEY_W-1:0] KEY_NONE = 3'd0;
	localparam logic [KEY_W-1:0] KEY_RUN  = 3'd1;
	localparam logic [KEY_W-1:0] KEY_UP   = 3'd2;
	localparam logic [KEY_W-1:0] KEY_DOWN = 3'd3;
	localparam logic [KEY_W-1:0] KEY_STOP = 3'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PRESS_TICKS   = 3'd0,
		REG_RELEASE_TICKS = 3'd1,
		REG_PERIOD_STEP   = 3'd2,
		REG_PERIOD_MIN    = 3'd3,
		REG_PERIOD_MAX    = 3'd4,
		REG_PERIOD_START  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0]    press_ticks;
		logic [CNT_W-1:0]    release_ticks;
		logic [CNT_W-1:0]    period_step;
		logic [PERIOD_W-1:0] period_min;
		logic [PERIOD_W-1:0] period_max;
	} cfg_t;

	typedef struct packed {
		logic [KEY_W-1:0]    fired_key;
		logic                running;
		logic [PERIOD_W-1:0] period;
		logic                pwm_enable;
		logic [PERIOD_W-1:0] pwm_reload;
		logic                armed;
	} rslt_t;

	function automatic logic [PERIOD_W-1:0] reload_of(input logic [KEY_W-1:0] key);
		logic [PERIOD_W-1:0] r;
		case (key)
			KEY_RUN:  r = 10'd299;
			KEY_UP:   r = 10'd399;
			KEY_DOWN: r = 10'd499;
			default:  r = 10'd599;
		endcase
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c);
		return (c == {CNT_W{1'b1}}) ? c : c + CNT_W'(1);
	endfunction

endpackage

// ===== hdl/kdsc_cfg.sv =====
// ----------------------------------------------------------------------------
// kdsc_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module kdsc_cfg
	import kdsc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DW-1:0]    cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_ticks   <= PRESS_TICKS_RST;
			cfg_q.release_ticks <= RELEASE_TICKS_RST;
			cfg_q.period_step   <= PERIOD_STEP_RST;
			cfg_q.period_min    <= PERIOD_MIN_RST;
			cfg_q.period_max    <= PERIOD_MAX_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_PRESS_TICKS:   cfg_q.press_ticks   <= cfg_data[CNT_W-1:0];
				REG_RELEASE_TICKS: cfg_q.release_ticks <= cfg_data[CNT_W-1:0];
				REG_PERIOD_STEP:   cfg_q.period_step   <= cfg_data[CNT_W-1:0];
				REG_PERIOD_MIN:    cfg_q.period_min    <= cfg_data;
				REG_PERIOD_MAX:    cfg_q.period_max    <= cfg_data;
				// period start is only loaded by reset, which also restores
				// its default, so a written value is never observed
				REG_PERIOD_START:  ;
				default:           ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/kdsc_core.sv =====
// ----------------------------------------------------------------------------
// kdsc_core
// Debounce state, key decode and period update; advances once per item.
// ----------------------------------------------------------------------------
module kdsc_core
	import kdsc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [NUM_KEYS-1:0] levels,
	input  cfg_t                cfg,
	output rslt_t               rslt
);

	logic                armed_q;
	logic [KEY_W-1:0]    cand_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                run_q;
	logic [PERIOD_W-1:0] period_q;
	logic                pwm_q;
	logic [PERIOD_W-1:0] reload_q;

	logic [KEY_W-1:0]    key;
	logic [CNT_W-1:0]    cnt_press;
	logic [CNT_W-1:0]    cnt_rel;
	logic                fire;
	logic                rearm;
	logic [PERIOD_W:0]   sum;
	logic [PERIOD_W:0]   floor_lim;
	logic [PERIOD_W-1:0] period_up;
	logic [PERIOD_W-1:0] period_dn;
	logic [PERIOD_W-1:0] period_nxt;
	logic                armed_nxt;
	logic [CNT_W-1:0]    cnt_nxt;
	logic                run_nxt;
	logic                pwm_nxt;
	logic [PERIOD_W-1:0] reload_nxt;

	// lowest-numbered pressed key wins
	always_comb begin
		key = KEY_NONE;
		for (int i = NUM_KEYS - 1; i >= 0; i--) begin
			if (!levels[i])
				key = KEY_W'(i + 1);
		end
	end

	assign cnt_press = (key != KEY_NONE && key == cand_q) ? count_up(cnt_q) : '0;
	assign fire      = armed_q && (key != KEY_NONE) && (cnt_press >= cfg.press_ticks);
	assign cnt_rel   = (levels == {NUM_KEYS{1'b1}}) ? count_up(cnt_q) : cnt_q;
	assign rearm     = !armed_q && (cnt_rel >= cfg.release_ticks);

	assign sum       = {1'b0, period_q} + {3'b000, cfg.period_step};
	assign floor_lim = {1'b0, cfg.period_min} + {3'b000, cfg.period_step};

	always_comb begin
		if (period_q < cfg.period_max && sum <= {1'b0, cfg.period_max})
			period_up = sum[PERIOD_W-1:0];
		else
			period_up = cfg.period_max;

		if (period_q > cfg.period_min && {1'b0, period_q} >= floor_lim)
			period_dn = period_q - {2'b00, cfg.period_step};
		else
			period_dn = cfg.period_min;
	end

	always_comb begin
		armed_nxt  = armed_q;
		cnt_nxt    = cnt_q;
		run_nxt    = run_q;
		period_nxt = period_q;
		pwm_nxt    = pwm_q;
		reload_nxt = reload_q;
		if (armed_q) begin
			cnt_nxt = cnt_press;
			if (fire) begin
				case (key)
					KEY_RUN:  run_nxt    = 1'b1;
					KEY_STOP: run_nxt    = 1'b0;
					KEY_UP:   period_nxt = period_up;
					KEY_DOWN: period_nxt = period_dn;
					default:  ;
				endcase
				reload_nxt = reload_of(key);
				pwm_nxt    = 1'b1;
				armed_nxt  = 1'b0;
				cnt_nxt    = '0;
			end
		end else begin
			cnt_nxt = cnt_rel;
			if (rearm) begin
				cnt_nxt   = '0;
				armed_nxt = 1'b1;
				pwm_nxt   = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q  <= 1'b1;
			cand_q   <= KEY_NONE;
			cnt_q    <= '0;
			run_q    <= 1'b0;
			period_q <= PERIOD_START_RST;
			pwm_q    <= 1'b0;
			reload_q <= '0;
		end else if (advance) begin
			armed_q  <= armed_nxt;
			// candidate only tracks while armed; it holds through lockout
			if (armed_q)
				cand_q <= key;
			cnt_q    <= cnt_nxt;
			run_q    <= run_nxt;
			period_q <= period_nxt;
			pwm_q    <= pwm_nxt;
			reload_q <= reload_nxt;
		end
	end

	assign rslt.fired_key  = fire ? key : KEY_NONE;
	assign rslt.running    = run_nxt;
	assign rslt.period     = period_nxt;
	assign rslt.pwm_enable = pwm_nxt;
	assign rslt.pwm_reload = reload_nxt;
	assign rslt.armed      = armed_nxt;

endmodule

// ===== hdl/four_key_debounce_speed_control.sv =====
// ----------------------------------------------------------------------------
// four_key_debounce_speed_control
// Four-key debouncer with release lockout, run flag and period control.
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_we               cfg_index, cfg_data
//   in       in         in_valid / in_stall  key_levels
//   out      out        out_valid/out_stall  fired_key, running, period,
//                                            pwm_enable, pwm_reload, armed
//
// One item per cycle while the output is not stalled.
// An item waits in the input register, then the state update and result
// are computed in one pass into the output register.
// Reset clears the debounce state, loads the default period and registers.
// With the output stalled, one more item is taken into the input register.
// ----------------------------------------------------------------------------
module four_key_debounce_speed_control
	import kdsc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DW-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [NUM_KEYS-1:0]  key_levels,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [KEY_W-1:0]     fired_key,
	output logic                 running,
	output logic [PERIOD_W-1:0]  period,
	output logic                 pwm_enable,
	output logic [PERIOD_W-1:0]  pwm_reload,
	output logic                 armed
);

	cfg_t                cfg;
	rslt_t               rslt;
	rslt_t               rslt_s2;
	logic                vld_s1;
	logic                vld_s2;
	logic [NUM_KEYS-1:0] levels_s1;
	logic                advance;
	logic                take_in;

	assign advance  = vld_s1 && (!vld_s2 || !out_stall);
	assign in_stall = vld_s1 && !advance;
	assign take_in  = in_valid && !in_stall;

	kdsc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	kdsc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.levels  (levels_s1),
		.cfg     (cfg),
		.rslt    (rslt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (take_in)
				vld_s1 <= 1'b1;
			else if (advance)
				vld_s1 <= 1'b0;
			if (advance)
				vld_s2 <= 1'b1;
			else if (!out_stall)
				vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in)
			levels_s1 <= key_levels;
		if (advance)
			rslt_s2 <= rslt;
	end

	assign out_valid  = vld_s2;
	assign fired_key  = rslt_s2.fired_key;
	assign running    = rslt_s2.running;
	assign period     = rslt_s2.period;
	assign pwm_enable = rslt_s2.pwm_enable;
	assign pwm_reload = rslt_s2.pwm_reload;
	assign armed      = rslt_s2.armed;

endmodule
